>>> design/sfd_pkg.sv
// Package for the sync-framed deframer with Fletcher-8 checksum.
// Holds phase codes, register indexes, reset values and shared structs.
// No dependencies.
package sfd_pkg;

    localparam int unsigned PhaseW = 4;
    localparam int unsigned IdleW  = 24;
    localparam int unsigned WordW  = 16;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 24;

    localparam logic [PhaseW-1:0] PH_SYNC1 = 4'd0;
    localparam logic [PhaseW-1:0] PH_SYNC2 = 4'd1;
    localparam logic [PhaseW-1:0] PH_CLASS = 4'd2;
    localparam logic [PhaseW-1:0] PH_MSGID = 4'd3;
    localparam logic [PhaseW-1:0] PH_LEN0  = 4'd4;
    localparam logic [PhaseW-1:0] PH_LEN1  = 4'd5;
    localparam logic [PhaseW-1:0] PH_DATA  = 4'd6;
    localparam logic [PhaseW-1:0] PH_CK0   = 4'd7;
    localparam logic [PhaseW-1:0] PH_CK1   = 4'd8;

    localparam logic [CfgIdxW-1:0] REG_SYNC_FIRST    = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_SYNC_SECOND   = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_TIMEOUT_TICKS = 2'd2;

    localparam logic [ByteW-1:0] SYNC_FIRST_RST  = 8'd181;
    localparam logic [ByteW-1:0] SYNC_SECOND_RST = 8'd98;
    localparam logic [IdleW-1:0] TIMEOUT_RST     = 24'd10000;
    localparam logic [IdleW-1:0] IDLE_MAX        = 24'hFFFFFF;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic [ByteW-1:0] sync_first;
        logic [ByteW-1:0] sync_second;
        logic [IdleW-1:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic             payload_valid;
        logic [ByteW-1:0] payload_byte;
        logic [WordW-1:0] payload_index;
        logic             frame_done;
        logic             checksum_ok;
        logic [WordW-1:0] message_id;
        logic [WordW-1:0] frame_length;
    } t_result;

endpackage

>>> design/sync_frame_deframer_fletcher_core.sv
// Top level of the sync-framed deframer with Fletcher-8 checksum.
// Depends on sfd_pkg, sfd_cfg and sfd_step.
//
// Each request (a received byte or one timer tick) yields exactly one result.
// A request is captured in an input register, decoded against the frame state
// combinationally, and the result lands in an output register; with the output
// taken every cycle the block sustains one request per clock. The result is
// registered when the output register is empty or being taken; while the output
// is held off the request waits in the input register and, once both registers
// are full, the input stalls. Configuration writes take effect on the next clock
// and should be made only while the block is idle.
module sync_frame_deframer_fletcher_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sfd_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [sfd_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_command,
    input  logic [7:0]                    i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_payload_valid,
    output logic [7:0]                    o_payload_byte,
    output logic [15:0]                   o_payload_index,
    output logic                          o_frame_done,
    output logic                          o_checksum_ok,
    output logic [15:0]                   o_message_id,
    output logic [15:0]                   o_frame_length
);

    sfd_pkg::t_cfg    cfg;
    sfd_pkg::t_result step_res;
    sfd_pkg::t_result r_res;

    logic       r_in_valid;
    logic       r_command;
    logic [7:0] r_data_byte;
    logic       r_out_valid;
    logic       advance;
    logic       fire;

    assign advance    = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    sfd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sfd_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_command   (r_command),
        .i_data_byte (r_data_byte),
        .i_cfg       (cfg),
        .o_result    (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_command   <= i_command;
            r_data_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_valid = r_res.payload_valid;
    assign o_payload_byte  = r_res.payload_byte;
    assign o_payload_index = r_res.payload_index;
    assign o_frame_done    = r_res.frame_done;
    assign o_checksum_ok   = r_res.checksum_ok;
    assign o_message_id    = r_res.message_id;
    assign o_frame_length  = r_res.frame_length;

endmodule

>>> design/sfd_cfg.sv
// Configuration registers: sync byte values and idle timeout.
// Depends on sfd_pkg.
module sfd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sfd_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [sfd_pkg::CfgDataW-1:0]  i_cfg_data,
    output sfd_pkg::t_cfg                 o_cfg
);

    sfd_pkg::t_cfg r_cfg;
    sfd_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                sfd_pkg::REG_SYNC_FIRST:    n_cfg.sync_first    = i_cfg_data[7:0];
                sfd_pkg::REG_SYNC_SECOND:   n_cfg.sync_second   = i_cfg_data[7:0];
                sfd_pkg::REG_TIMEOUT_TICKS: n_cfg.timeout_ticks = i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first    <= sfd_pkg::SYNC_FIRST_RST;
            r_cfg.sync_second   <= sfd_pkg::SYNC_SECOND_RST;
            r_cfg.timeout_ticks <= sfd_pkg::TIMEOUT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/sfd_step.sv
// Frame decode state and its one-item update: timeout, phase FSM, Fletcher-8.
// Depends on sfd_pkg.
module sfd_step (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic                       i_command,
    input  logic [sfd_pkg::ByteW-1:0]  i_data_byte,
    input  sfd_pkg::t_cfg              i_cfg,
    output sfd_pkg::t_result           o_result
);

    logic [sfd_pkg::PhaseW-1:0] r_phase, n_phase;
    logic [sfd_pkg::WordW-1:0]  r_left, n_left;
    logic [sfd_pkg::WordW-1:0]  r_id, n_id;
    logic [sfd_pkg::WordW-1:0]  r_len, n_len;
    logic [sfd_pkg::ByteW-1:0]  r_sum_lo, n_sum_lo;
    logic [sfd_pkg::ByteW-1:0]  r_sum_hi, n_sum_hi;
    logic [sfd_pkg::ByteW-1:0]  r_ck_lo, n_ck_lo;
    logic [sfd_pkg::IdleW-1:0]  r_idle, n_idle;

    logic [sfd_pkg::PhaseW-1:0] phase_eff;
    logic [sfd_pkg::WordW-1:0]  left_eff;
    logic [sfd_pkg::WordW-1:0]  left_dec;
    logic                       timed_out;
    logic [sfd_pkg::ByteW-1:0]  add_lo;
    logic [sfd_pkg::ByteW-1:0]  add_hi;
    logic [sfd_pkg::ByteW-1:0]  base_lo;
    logic [sfd_pkg::ByteW-1:0]  base_hi;

    always_comb begin
        n_idle = r_idle;
        if (i_command == sfd_pkg::CMD_TICK && r_idle != sfd_pkg::IDLE_MAX) begin
            n_idle = r_idle + 24'd1;
        end
        timed_out = n_idle > i_cfg.timeout_ticks;
        phase_eff = timed_out ? sfd_pkg::PH_SYNC1 : r_phase;
        left_eff  = timed_out ? '0 : r_left;
        left_dec  = left_eff - 16'd1;

        // class byte starts a fresh sum
        base_lo = (phase_eff == sfd_pkg::PH_CLASS) ? '0 : r_sum_lo;
        base_hi = (phase_eff == sfd_pkg::PH_CLASS) ? '0 : r_sum_hi;
        add_lo  = base_lo + i_data_byte;
        add_hi  = base_hi + add_lo;

        n_phase  = phase_eff;
        n_left   = left_eff;
        n_id     = r_id;
        n_len    = r_len;
        n_sum_lo = r_sum_lo;
        n_sum_hi = r_sum_hi;
        n_ck_lo  = r_ck_lo;

        o_result               = '0;

        if (i_command == sfd_pkg::CMD_BYTE) begin
            unique case (phase_eff)
                sfd_pkg::PH_SYNC2: begin
                    n_phase = (i_data_byte == i_cfg.sync_second) ?
                              sfd_pkg::PH_CLASS : sfd_pkg::PH_SYNC1;
                end
                sfd_pkg::PH_CLASS: begin
                    n_id     = {8'd0, i_data_byte};
                    n_sum_lo = add_lo;
                    n_sum_hi = add_hi;
                    n_phase  = sfd_pkg::PH_MSGID;
                end
                sfd_pkg::PH_MSGID: begin
                    n_id     = {i_data_byte, r_id[7:0]};
                    n_sum_lo = add_lo;
                    n_sum_hi = add_hi;
                    n_phase  = sfd_pkg::PH_LEN0;
                end
                sfd_pkg::PH_LEN0: begin
                    n_len    = {8'd0, i_data_byte};
                    n_sum_lo = add_lo;
                    n_sum_hi = add_hi;
                    n_phase  = sfd_pkg::PH_LEN1;
                end
                sfd_pkg::PH_LEN1: begin
                    n_len    = {i_data_byte, r_len[7:0]};
                    n_left   = {i_data_byte, r_len[7:0]};
                    n_sum_lo = add_lo;
                    n_sum_hi = add_hi;
                    n_phase  = ({i_data_byte, r_len[7:0]} != '0) ?
                               sfd_pkg::PH_DATA : sfd_pkg::PH_CK0;
                end
                sfd_pkg::PH_DATA: begin
                    o_result.payload_valid = 1'b1;
                    o_result.payload_byte  = i_data_byte;
                    o_result.payload_index = r_len - left_eff;
                    n_sum_lo = add_lo;
                    n_sum_hi = add_hi;
                    n_left   = left_dec;
                    if (left_dec == '0) begin
                        n_phase = sfd_pkg::PH_CK0;
                    end
                end
                sfd_pkg::PH_CK0: begin
                    n_ck_lo = i_data_byte;
                    n_phase = sfd_pkg::PH_CK1;
                end
                sfd_pkg::PH_CK1: begin
                    o_result.frame_done  = 1'b1;
                    o_result.checksum_ok = (r_ck_lo == r_sum_lo) &&
                                           (i_data_byte == r_sum_hi);
                    n_phase = sfd_pkg::PH_SYNC1;
                end
                default: begin
                    n_phase = (i_data_byte == i_cfg.sync_first) ?
                              sfd_pkg::PH_SYNC2 : sfd_pkg::PH_SYNC1;
                    n_idle  = '0;
                end
            endcase
        end

        o_result.message_id   = n_id;
        o_result.frame_length = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= sfd_pkg::PH_SYNC1;
            r_left   <= '0;
            r_id     <= '0;
            r_len    <= '0;
            r_sum_lo <= '0;
            r_sum_hi <= '0;
            r_ck_lo  <= '0;
            r_idle   <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_left   <= n_left;
            r_id     <= n_id;
            r_len    <= n_len;
            r_sum_lo <= n_sum_lo;
            r_sum_hi <= n_sum_hi;
            r_ck_lo  <= n_ck_lo;
            r_idle   <= n_idle;
        end
    end

endmodule

>>> bench/sync_frame_deframer_fletcher_core_test.sv
// Testbench for sync_frame_deframer_fletcher_core: directed and random byte/tick
// traffic, with a per-request decoder model that checks every result in order.
// Depends on sfd_pkg and the core RTL only.
`timescale 1ns / 1ps

module sync_frame_deframer_fletcher_core_test;
    import sfd_pkg::*;

    localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd3;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SHORT_TIMEOUT  = 64;
    localparam int PHASE_ITEMS    = 175;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_command;
    logic [7:0]          i_data_byte;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_payload_valid;
    logic [7:0]          o_payload_byte;
    logic [15:0]         o_payload_index;
    logic                o_frame_done;
    logic                o_checksum_ok;
    logic [15:0]         o_message_id;
    logic [15:0]         o_frame_length;

    sync_frame_deframer_fletcher_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_payload_valid (o_payload_valid),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_frame_done    (o_frame_done),
        .o_checksum_ok   (o_checksum_ok),
        .o_message_id    (o_message_id),
        .o_frame_length  (o_frame_length)
    );

    // decoder model state
    t_cfg             dec_cfg;
    logic [PhaseW-1:0] dec_phase;
    logic [15:0]      dec_left;
    logic [15:0]      dec_id;
    logic [15:0]      dec_len;
    logic [15:0]      dec_sums;   // {B, A}
    logic [7:0]       dec_ck_lo;
    logic [IdleW-1:0] dec_idle;

    t_result pending_decodes[$];

    int items_sent;
    int results_seen;
    int frames_closed;
    int frames_good;
    int payload_bytes;
    int frames_dropped;
    int mismatches;
    int fail_count;
    int in_idle_pct;
    int out_idle_pct;
    int stall_cycles;
    bit hold_request;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] fletcher_next(input logic [15:0] sums, input logic [7:0] b);
        logic [7:0] a;
        a = sums[7:0] + b;
        return {sums[15:8] + a, a};
    endfunction

    function automatic int idle_gap();
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(10, 40));
        return int'($urandom_range(1, 3));
    endfunction

    function automatic t_result deframe_item(input logic cmd, input logic [7:0] b);
        t_result r;
        r = '0;
        if (cmd == CMD_TICK && dec_idle != IDLE_MAX)
            dec_idle = dec_idle + 24'd1;
        if (dec_idle > dec_cfg.timeout_ticks) begin
            if (dec_phase != PH_SYNC1)
                frames_dropped++;
            dec_phase = PH_SYNC1;
            dec_left  = '0;
        end
        if (cmd == CMD_BYTE) begin
            case (dec_phase)
                PH_SYNC2: dec_phase = (b == dec_cfg.sync_second) ? PH_CLASS : PH_SYNC1;
                PH_CLASS: begin
                    dec_id    = {8'h00, b};
                    dec_sums  = fletcher_next(16'h0000, b);
                    dec_phase = PH_MSGID;
                end
                PH_MSGID: begin
                    dec_id[15:8] = b;
                    dec_sums     = fletcher_next(dec_sums, b);
                    dec_phase    = PH_LEN0;
                end
                PH_LEN0: begin
                    dec_len   = {8'h00, b};
                    dec_sums  = fletcher_next(dec_sums, b);
                    dec_phase = PH_LEN1;
                end
                PH_LEN1: begin
                    dec_len[15:8] = b;
                    dec_sums      = fletcher_next(dec_sums, b);
                    dec_left      = dec_len;
                    dec_phase     = (dec_left != 16'h0000) ? PH_DATA : PH_CK0;
                end
                PH_DATA: begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    r.payload_index = dec_len - dec_left;
                    dec_sums        = fletcher_next(dec_sums, b);
                    dec_left        = dec_left - 16'd1;
                    if (dec_left == 16'h0000)
                        dec_phase = PH_CK0;
                end
                PH_CK0: begin
                    dec_ck_lo = b;
                    dec_phase = PH_CK1;
                end
                PH_CK1: begin
                    r.frame_done  = 1'b1;
                    r.checksum_ok = (dec_ck_lo == dec_sums[7:0]) && (b == dec_sums[15:8]);
                    dec_phase     = PH_SYNC1;
                end
                default: begin
                    dec_phase = (b == dec_cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
                    dec_idle  = '0;
                end
            endcase
        end
        r.message_id   = dec_id;
        r.frame_length = dec_len;
        return r;
    endfunction

    // Returns at the rising edge where the request is taken.
    task automatic send_request(input logic cmd, input logic [7:0] b);
        t_result r;
        @(negedge i_clk);
        if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat (idle_gap()) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        r = deframe_item(cmd, b);
        pending_decodes.push_back(r);
        items_sent++;
        if (r.payload_valid)
            payload_bytes++;
        if (r.frame_done) begin
            frames_closed++;
            if (r.checksum_ok)
                frames_good++;
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_SYNC_FIRST:    dec_cfg.sync_first    = data[7:0];
            REG_SYNC_SECOND:   dec_cfg.sync_second   = data[7:0];
            REG_TIMEOUT_TICKS: dec_cfg.timeout_ticks = data;
            default: ;
        endcase
    endtask

    // Frame with n_sent payload bytes; the checksum goes out only if the payload is complete.
    task automatic send_frame(input logic [15:0] id, input logic [15:0] len, input int n_sent,
                              input bit bad_sum, input int tick_pct, input bit random_fill);
        logic [7:0]  seq[$];
        logic [15:0] sums;
        logic [7:0]  b;
        int i;
        if (dec_cfg.timeout_ticks < SHORT_TIMEOUT)
            while (dec_phase != PH_SYNC1) send_request(CMD_TICK, 8'($urandom));
        seq  = {id[7:0], id[15:8], len[7:0], len[15:8]};
        sums = '0;
        foreach (seq[k]) sums = fletcher_next(sums, seq[k]);
        for (i = 0; i < n_sent; i++) begin
            b    = random_fill ? 8'($urandom) : (i[0] ? 8'h00 : 8'hFF);
            sums = fletcher_next(sums, b);
            seq.push_back(b);
        end
        if (n_sent == int'(len)) begin
            if (bad_sum)
                sums = sums ^ 16'($urandom_range(1, 65535));
            seq.push_back(sums[7:0]);
            seq.push_back(sums[15:8]);
        end
        send_request(CMD_BYTE, dec_cfg.sync_first);
        send_request(CMD_BYTE, dec_cfg.sync_second);
        foreach (seq[k]) begin
            if (tick_pct != 0 && $urandom_range(0, 99) < tick_pct)
                send_request(CMD_TICK, 8'($urandom));
            send_request(CMD_BYTE, seq[k]);
        end
    endtask

    task automatic run_directed_frames();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        // a repeated first sync byte in the second slot must not restart the frame
        send_request(CMD_BYTE, SYNC_FIRST_RST);
        send_request(CMD_BYTE, SYNC_FIRST_RST);
        send_request(CMD_BYTE, SYNC_SECOND_RST);
        send_frame(16'hFFFF, 16'h0000, 0, 1'b0, 0, 1'b0);
        send_frame(16'h0000, 16'h0001, 1, 1'b1, 0, 1'b0);
        send_frame(16'h5AA5, 16'h0002, 2, 1'b0, 0, 1'b0);
    endtask

    task automatic run_timeout_cases();
        drain();
        write_reg(REG_TIMEOUT_TICKS, 24'd0);
        send_request(CMD_BYTE, dec_cfg.sync_first);
        send_request(CMD_BYTE, dec_cfg.sync_second);
        send_request(CMD_TICK, 8'hA5);
        send_request(CMD_BYTE, 8'h00);
        drain();
        write_reg(REG_SYNC_FIRST, 24'h000000);
        write_reg(REG_SYNC_SECOND, 24'h0000FF);
        write_reg(REG_TIMEOUT_TICKS, 24'd2);
        write_reg(REG_SPARE, 24'hFFFFFF);
        send_request(CMD_BYTE, 8'h00);
        send_request(CMD_BYTE, 8'hFF);
        send_request(CMD_TICK, 8'h5A);
        send_request(CMD_TICK, 8'h00);
        send_request(CMD_BYTE, 8'h12);
        send_request(CMD_TICK, 8'hFF);
        send_request(CMD_BYTE, 8'h00);
    endtask

    task automatic run_backpressure();
        int i;
        drain();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        hold_request = 1'b1;
        for (i = 0; i < 4; i++)
            send_frame(16'($urandom), 16'd6, 6, 1'b0, 0, 1'b1);
        drain();
    endtask

    task automatic run_random_traffic();
        int p, first, r, len, n, tick_pct;
        bit short_to;
        logic [7:0] b;
        for (p = 0; p < 6; p++) begin
            drain();
            case (p)
                0: begin
                    write_reg(REG_SYNC_FIRST, 24'($urandom_range(0, 255)));
                    write_reg(REG_SYNC_SECOND, 24'($urandom_range(0, 255)));
                    write_reg(REG_TIMEOUT_TICKS, IDLE_MAX);
                end
                1: begin
                    write_reg(REG_SYNC_FIRST, 24'(SYNC_FIRST_RST));
                    write_reg(REG_SYNC_SECOND, 24'(SYNC_SECOND_RST));
                    write_reg(REG_TIMEOUT_TICKS, 24'($urandom_range(3, 20)));
                end
                2: begin
                    write_reg(REG_SYNC_FIRST, 24'h000000);
                    write_reg(REG_SYNC_SECOND, 24'h0000FF);
                    write_reg(REG_TIMEOUT_TICKS, 24'd0);
                end
                3: begin
                    write_reg(REG_SYNC_FIRST, 24'($urandom_range(0, 255)));
                    write_reg(REG_SYNC_SECOND, 24'($urandom_range(0, 255)));
                    write_reg(REG_TIMEOUT_TICKS, 24'($urandom_range(1, 8)));
                end
                4: begin
                    write_reg(REG_SYNC_FIRST, 24'h0000FF);
                    write_reg(REG_SYNC_SECOND, 24'h000000);
                    write_reg(REG_TIMEOUT_TICKS, 24'($urandom_range(100000, 24'hFFFFFE)));
                end
                default: begin
                    write_reg(REG_SYNC_FIRST, 24'($urandom_range(0, 255)));
                    write_reg(REG_SYNC_SECOND, 24'($urandom_range(0, 255)));
                    write_reg(REG_TIMEOUT_TICKS, 24'($urandom_range(4, 40)));
                end
            endcase
            in_idle_pct  = 20 * int'($urandom_range(0, 2));
            out_idle_pct = 20 * int'($urandom_range(0, 2));
            short_to     = dec_cfg.timeout_ticks < SHORT_TIMEOUT;
            tick_pct     = short_to ? 3 : 8;
            first        = items_sent;
            while (items_sent - first < PHASE_ITEMS) begin
                r = int'($urandom_range(0, 99));
                if (r < 60) begin
                    len = ($urandom_range(0, 19) == 0) ? int'($urandom_range(13, 60))
                                                       : int'($urandom_range(0, 12));
                    send_frame(16'($urandom), 16'(len), len, $urandom_range(0, 99) < 15,
                               tick_pct, 1'b1);
                end else if (r < 72 && short_to) begin
                    // partial frame, left for the timeout to clear
                    len = ($urandom_range(0, 2) == 0) ? 65535 : int'($urandom_range(4, 300));
                    send_frame(16'($urandom), 16'(len), int'($urandom_range(0, 3)), 1'b0,
                               0, 1'b1);
                end else if (r < 85) begin
                    send_request(CMD_BYTE, dec_cfg.sync_first);
                    do b = 8'($urandom); while (b == dec_cfg.sync_second);
                    send_request(CMD_BYTE, b);
                end else begin
                    n = int'($urandom_range(1, 4));
                    repeat (n) begin
                        do b = 8'($urandom); while (!short_to && b == dec_cfg.sync_first);
                        send_request(($urandom_range(0, 2) == 0) ? CMD_TICK : CMD_BYTE, b);
                    end
                    if (r == 99)
                        drain();
                end
            end
        end
    endtask

    // receiver: random gaps, plus one long hold on request
    initial begin
        int gap_left;
        gap_left    = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                gap_left     = HOLD_CYCLES;
            end else if (gap_left == 0 && out_idle_pct != 0
                         && $urandom_range(0, 99) < out_idle_pct) begin
                gap_left = idle_gap();
            end
            if (gap_left > 0) begin
                gap_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.payload_valid = o_payload_valid;
            got.payload_byte  = o_payload_byte;
            got.payload_index = o_payload_index;
            got.frame_done    = o_frame_done;
            got.checksum_ok   = o_checksum_ok;
            got.message_id    = o_message_id;
            got.frame_length  = o_frame_length;
            results_seen++;
            if (pending_decodes.size() == 0) begin
                fail_count++;
                mismatches++;
                if (mismatches <= 10)
                    $display("Result %0d arrived with nothing outstanding", results_seen);
            end else begin
                want = pending_decodes.pop_front();
                if (got !== want) begin
                    fail_count++;
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch on result %0d:", results_seen);
                        $display("  exp pv=%0d pb=%02h pi=%0d fd=%0d ok=%0d id=%04h len=%04h",
                                 want.payload_valid, want.payload_byte, want.payload_index,
                                 want.frame_done, want.checksum_ok, want.message_id,
                                 want.frame_length);
                        $display("  got pv=%0d pb=%02h pi=%0d fd=%0d ok=%0d id=%04h len=%04h",
                                 got.payload_valid, got.payload_byte, got.payload_index,
                                 got.frame_done, got.checksum_ok, got.message_id,
                                 got.frame_length);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_command    = CMD_BYTE;
        i_data_byte  = '0;
        hold_request = 1'b0;
        in_idle_pct  = 0;
        out_idle_pct = 0;
        stall_cycles = 0;
        items_sent   = 0;
        results_seen = 0;
        frames_closed  = 0;
        frames_good    = 0;
        payload_bytes  = 0;
        frames_dropped = 0;
        mismatches   = 0;
        fail_count   = 0;
        dec_cfg      = '{sync_first: SYNC_FIRST_RST, sync_second: SYNC_SECOND_RST,
                         timeout_ticks: TIMEOUT_RST};
        dec_phase    = PH_SYNC1;
        dec_left     = '0;
        dec_id       = '0;
        dec_len      = '0;
        dec_sums     = '0;
        dec_ck_lo    = '0;
        dec_idle     = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed_frames();
        run_timeout_cases();
        run_backpressure();
        run_random_traffic();

        drain();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d requests / %0d results: %0d frames closed (%0d checksum ok),",
                 items_sent, results_seen, frames_closed, frames_good);
        $display("%0d payload bytes, %0d partial frames dropped on timeout, %0d mismatches.",
                 payload_bytes, frames_dropped, mismatches);
        if (fail_count == 0 && pending_decodes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
design/sfd_pkg.sv
design/sfd_cfg.sv
design/sfd_step.sv
design/sync_frame_deframer_fletcher_core.sv
bench/sync_frame_deframer_fletcher_core_test.sv
